### sv/afmt_pkg.sv
// Shared types and constants for the allocation/free match tracker.
// Used by afmt_ctrl, afmt_datapath and alloc_free_match_tracker; depends on nothing.
package afmt_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_ADDR_BITS   = 32;

    localparam int AFMT_ADDR_W = 32;
    localparam int AFMT_SEQ_W  = 16;
    localparam int AFMT_KIND_W = 3;
    localparam int AFMT_REQ_W  = 2;

    typedef enum logic [AFMT_REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_END   = 2'd2
    } req_code_t;

    typedef enum logic [AFMT_KIND_W-1:0] {
        RK_MATCHED_FREE   = 3'd0,
        RK_UNMATCHED_FREE = 3'd1,
        RK_UNMATCHED_ALLC = 3'd2,
        RK_OVERFLOW       = 3'd3,
        RK_SUMMARY        = 3'd4
    } result_kind_t;

    typedef struct packed {
        logic alloc;
        logic lookup;
        logic resolve;
        logic drain;
        logic summary;
    } afmt_cmd_t;

    typedef struct packed {
        logic empty;
    } afmt_status_t;

endpackage

### sv/afmt_ctrl.sv
// Controller state machine of the allocation/free match tracker.
// Depends on afmt_pkg for the command and status structs and request codes.
module afmt_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [afmt_pkg::AFMT_REQ_W-1:0] req_type,
    input  afmt_pkg::afmt_status_t         status,
    output afmt_pkg::afmt_cmd_t            cmd,
    output logic                           busy
);
    import afmt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_ALLOC:
                        begin
                            cmd.alloc = 1'b1;
                        end
                        REQ_FREE:
                        begin
                            cmd.lookup = 1'b1;
                            state_next = ST_FREE;
                        end
                        REQ_END:
                        begin
                            state_next = ST_DRAIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FREE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (status.empty)
                begin
                    cmd.summary = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.drain = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

`ifndef SYNTH
    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != ST_IDLE))
        else $error("busy does not match controller state");
    a_free_resolves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> cmd.resolve)
        else $error("free lookup not followed by resolve");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

### sv/afmt_datapath.sv
// Datapath of the allocation/free match tracker: ordered allocation table,
// parallel free lookup, counters and result registers. Depends on afmt_pkg.
module afmt_datapath #(
    parameter int TABLE_DEPTH = afmt_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = afmt_pkg::DEF_ADDR_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  afmt_pkg::afmt_cmd_t              cmd,
    input  logic [afmt_pkg::AFMT_ADDR_W-1:0] address,
    output afmt_pkg::afmt_status_t           status,
    output logic                             result_valid,
    output logic [afmt_pkg::AFMT_KIND_W-1:0] result_kind,
    output logic [afmt_pkg::AFMT_SEQ_W-1:0]  event_index,
    output logic [afmt_pkg::AFMT_SEQ_W-1:0]  partner_index,
    output logic [afmt_pkg::AFMT_ADDR_W-1:0] event_address,
    output logic [afmt_pkg::AFMT_SEQ_W-1:0]  unmatched_total,
    output logic                             last_result
);
    import afmt_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int KEEP_W = (ADDR_BITS < AFMT_ADDR_W) ? ADDR_BITS : AFMT_ADDR_W;

    logic [KEEP_W-1:0]     tbl_addr_reg [TABLE_DEPTH];
    logic [AFMT_SEQ_W-1:0] tbl_seq_reg  [TABLE_DEPTH];

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [AFMT_SEQ_W-1:0]  seq_reg, seq_next;
    logic [AFMT_SEQ_W-1:0]  unm_reg, unm_next;
    logic [KEEP_W-1:0]      req_addr_reg, req_addr_next;
    logic [AFMT_SEQ_W-1:0]  req_seq_reg, req_seq_next;
    logic [TABLE_DEPTH-1:0] match_reg, match_next;

    logic                   res_valid_reg, res_valid_next;
    result_kind_t           res_kind_reg, res_kind_next;
    logic [AFMT_SEQ_W-1:0]  res_event_reg, res_event_next;
    logic [AFMT_SEQ_W-1:0]  res_partner_reg, res_partner_next;
    logic [KEEP_W-1:0]      res_addr_reg, res_addr_next;
    logic [AFMT_SEQ_W-1:0]  res_total_reg, res_total_next;
    logic                   res_last_reg, res_last_next;

    logic [KEEP_W-1:0]      addr_in;
    logic                   full;
    logic                   hit;
    logic [TABLE_DEPTH-1:0] at_or_above;
    logic [TABLE_DEPTH-1:0] hit_onehot;
    logic [AFMT_SEQ_W-1:0]  partner_seq;
    logic [AFMT_SEQ_W-1:0]  unm_bumped;
    logic                   store;
    logic                   shift_any;

    assign addr_in      = address[KEEP_W-1:0];
    assign full         = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit          = |match_reg;
    assign unm_bumped   = (unm_reg == '1) ? unm_reg : unm_reg + 1'b1;
    assign store        = cmd.alloc && !full;
    assign shift_any    = (cmd.resolve && hit) || cmd.drain;
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        partner_seq = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_next[i]  = (CNT_W'(i) < count_reg) && (tbl_addr_reg[i] == addr_in);
            at_or_above[i] = |(match_reg >> i);
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
            begin
                hit_onehot[i] = at_or_above[i];
            end
            else
            begin
                hit_onehot[i] = at_or_above[i] && !at_or_above[i + 1];
            end
            partner_seq = partner_seq | (hit_onehot[i] ? tbl_seq_reg[i] : '0);
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        seq_next         = seq_reg;
        unm_next         = unm_reg;
        req_addr_next    = req_addr_reg;
        req_seq_next     = req_seq_reg;
        res_valid_next   = 1'b0;
        res_kind_next    = res_kind_reg;
        res_event_next   = res_event_reg;
        res_partner_next = '0;
        res_addr_next    = res_addr_reg;
        res_total_next   = '0;
        res_last_next    = 1'b1;
        priority if (cmd.alloc)
        begin
            seq_next = seq_reg + 1'b1;
            if (full)
            begin
                unm_next       = unm_bumped;
                res_valid_next = 1'b1;
                res_kind_next  = RK_OVERFLOW;
                res_event_next = seq_reg;
                res_addr_next  = addr_in;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.lookup)
        begin
            seq_next      = seq_reg + 1'b1;
            req_addr_next = addr_in;
            req_seq_next  = seq_reg;
        end
        else if (cmd.resolve)
        begin
            res_valid_next = 1'b1;
            res_event_next = req_seq_reg;
            res_addr_next  = req_addr_reg;
            if (hit)
            begin
                count_next       = count_reg - 1'b1;
                res_kind_next    = RK_MATCHED_FREE;
                res_partner_next = partner_seq;
            end
            else
            begin
                unm_next      = unm_bumped;
                res_kind_next = RK_UNMATCHED_FREE;
            end
        end
        else if (cmd.drain)
        begin
            count_next     = count_reg - 1'b1;
            unm_next       = unm_bumped;
            res_valid_next = 1'b1;
            res_kind_next  = RK_UNMATCHED_ALLC;
            res_event_next = tbl_seq_reg[0];
            res_addr_next  = tbl_addr_reg[0];
            res_last_next  = 1'b0;
        end
        else if (cmd.summary)
        begin
            seq_next       = '0;
            unm_next       = '0;
            res_valid_next = 1'b1;
            res_kind_next  = RK_SUMMARY;
            res_event_next = seq_reg;
            res_addr_next  = '0;
            res_total_next = unm_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seq_reg       <= '0;
            unm_reg       <= '0;
            match_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            unm_reg       <= unm_next;
            match_reg     <= cmd.lookup ? match_next : match_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_addr_reg    <= req_addr_next;
        req_seq_reg     <= req_seq_next;
        res_kind_reg    <= res_kind_next;
        res_event_reg   <= res_event_next;
        res_partner_reg <= res_partner_next;
        res_addr_reg    <= res_addr_next;
        res_total_reg   <= res_total_next;
        res_last_reg    <= res_last_next;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_slot
        if (g < TABLE_DEPTH - 1)
        begin : g_inner
            always_ff @(posedge clk)
            begin
                if (store && (count_reg == CNT_W'(g)))
                begin
                    tbl_addr_reg[g] <= addr_in;
                    tbl_seq_reg[g]  <= seq_reg;
                end
                else if (shift_any && (cmd.drain || !at_or_above[g + 1]))
                begin
                    tbl_addr_reg[g] <= tbl_addr_reg[g + 1];
                    tbl_seq_reg[g]  <= tbl_seq_reg[g + 1];
                end
            end
        end
        else
        begin : g_top
            always_ff @(posedge clk)
            begin
                if (store && (count_reg == CNT_W'(g)))
                begin
                    tbl_addr_reg[g] <= addr_in;
                    tbl_seq_reg[g]  <= seq_reg;
                end
            end
        end
    end

    assign result_valid    = res_valid_reg;
    assign result_kind     = res_kind_reg;
    assign event_index     = res_event_reg;
    assign partner_index   = res_partner_reg;
    assign event_address   = AFMT_ADDR_W'(res_addr_reg);
    assign unmatched_total = res_total_reg;
    assign last_result     = res_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table occupancy beyond depth");
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_kind_reg == RK_SUMMARY) |-> (res_last_reg && count_reg == '0))
        else $error("summary not final or table not empty");
    a_drain_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_kind_reg == RK_UNMATCHED_ALLC) |-> !res_last_reg)
        else $error("drained allocation marked final");
    a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve |-> $onehot0(hit_onehot))
        else $error("free matched more than one slot");
`endif

endmodule

### sv/alloc_free_match_tracker.sv
// Top level of the allocation/free match tracker: joins controller and datapath.
// Depends on afmt_pkg, afmt_ctrl and afmt_datapath.
//
// An item is taken when start is high and busy is low. An allocation is handled
// in its accepting cycle and, only when the table is full, gives its overflow
// result in the next cycle. A free first compares the address against every
// table slot at once and registers the matches; then, in ST_FREE, it picks the
// youngest match, removes it and registers the result. An end marker is taken,
// then one result per cycle comes from the bottom of the table, the summary
// last. Results are shown for one cycle under result_valid and cannot be held
// off. Request code 3 is taken and ignored.
module alloc_free_match_tracker #(
    parameter int TABLE_DEPTH = afmt_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = afmt_pkg::DEF_ADDR_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [afmt_pkg::AFMT_REQ_W-1:0]  req_type,
    input  logic [afmt_pkg::AFMT_ADDR_W-1:0] address,
    output logic                             result_valid,
    output logic [afmt_pkg::AFMT_KIND_W-1:0] result_kind,
    output logic [afmt_pkg::AFMT_SEQ_W-1:0]  event_index,
    output logic [afmt_pkg::AFMT_SEQ_W-1:0]  partner_index,
    output logic [afmt_pkg::AFMT_ADDR_W-1:0] event_address,
    output logic [afmt_pkg::AFMT_SEQ_W-1:0]  unmatched_total,
    output logic                             last_result
);
    import afmt_pkg::*;

    afmt_cmd_t    cmd;
    afmt_status_t status;

    afmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    afmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .address         (address),
        .status          (status),
        .result_valid    (result_valid),
        .result_kind     (result_kind),
        .event_index     (event_index),
        .partner_index   (partner_index),
        .event_address   (event_address),
        .unmatched_total (unmatched_total),
        .last_result     (last_result)
    );

endmodule
